FILE: src/gtmf_pkg.sv
// Shared types, constants and the majority function of the gray threshold
// majority filter. No dependencies.
package gtmf_pkg;

  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [7:0]  THRESHOLD_RESET    = 8'd0;
  localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

  // Division of a sum of three bytes by three as a reciprocal multiply.
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic             x;
    logic             last_col;
    logic             last_row;
    logic [ROW_W-1:0] row;
  } pix_info_t;

  typedef struct packed {
    logic                 white;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 last_of_run;
    logic                 frame_done;
  } res_t;

  // Window bit r*3+c; row 0 is the oldest row, column 0 the oldest column.
  function automatic logic majority(logic [8:0] w, logic [1:0] r0, logic [1:0] c0);
    logic [3:0] total;
    logic [3:0] white;
    total = 4'd0;
    white = 4'd0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r >= int'(r0) && c >= int'(c0)) begin
          total = total + 4'd1;
          white = white + {3'b000, w[r*3+c]};
        end
      end
    end
    return {white, 1'b0} > {1'b0, total};
  endfunction

endpackage

FILE: src/gtmf_pix_if.sv
// Input pixel channel of the gray threshold majority filter.
// Depends on nothing.
interface gtmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source(output valid, blue, green, red, input ready);
  modport sink(input valid, blue, green, red, output ready);
endinterface

FILE: src/gtmf_res_if.sv
// Result channel of the gray threshold majority filter.
// Depends on nothing.
interface gtmf_res_if;
  logic        valid;
  logic        ready;
  logic        white;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        last_of_run;
  logic        frame_done;

  modport source(output valid, white, out_row, out_col, last_of_run, frame_done,
                 input ready);
  modport sink(input valid, white, out_row, out_col, last_of_run, frame_done,
               output ready);
endinterface

FILE: src/gtmf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module gtmf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/gtmf_front.sv
// Input stage: gray conversion, threshold, raster counters and line store read.
// Depends on gtmf_pkg and gtmf_pix_if.
module gtmf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  gtmf_pix_if.sink                   pix,
  input  logic [7:0]                 threshold,
  input  logic [10:0]                frame_width,
  input  logic [11:0]                frame_height,
  input  logic                       b_ready,
  output logic                       accept,
  output logic [CW-1:0]              col,
  output gtmf_pkg::pix_info_t        info
);

  logic [CW-1:0]              column_count;
  logic [gtmf_pkg::ROW_W-1:0] row_count;
  logic [9:0]                 sum;
  logic [19:0]                prod;
  logic [7:0]                 gray;
  logic [12:0]                w_eff;
  logic [12:0]                w_last;
  logic [11:0]                h_eff;
  logic [11:0]                h_last;
  logic                       last_col;
  logic                       last_row;

  assign sum  = 10'(pix.blue) + 10'(pix.green) + 10'(pix.red);
  assign prod = 20'(sum) * 20'(gtmf_pkg::DIV3_MUL);
  assign gray = prod[gtmf_pkg::DIV3_SHIFT +: 8];

  always_comb begin
    if (frame_width < 11'd2) begin
      w_eff = 13'd2;
    end else if (13'(frame_width) > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end else begin
      w_eff = 13'(frame_width);
    end
    h_eff = (frame_height < 12'd2) ? 12'd2 : frame_height;
  end

  assign w_last   = w_eff - 13'd1;
  assign h_last   = h_eff - 12'd1;
  assign last_col = 13'(column_count) >= w_last;
  assign last_row = row_count >= h_last;

  assign pix.ready = b_ready;
  assign accept    = pix.valid && b_ready;
  assign col       = column_count;

  always_comb begin
    info.x        = gray > threshold;
    info.last_col = last_col;
    info.last_row = last_row;
    info.row      = row_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 12'd1;
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

endmodule

FILE: src/gtmf_back.sv
// Window stage and result queue: line store write-back, 3x3 window shift,
// majority results per item, delivered one per cycle when res is ready.
// Depends on gtmf_pkg and gtmf_res_if.
module gtmf_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [CW-1:0]       col_in,
  input  gtmf_pkg::pix_info_t info_in,
  input  logic [1:0]          line_rd,
  output logic                b_ready,
  output logic                line_wr_en,
  output logic [CW-1:0]       line_wr_addr,
  output logic [1:0]          line_wr_data,
  gtmf_res_if.source          res
);

  logic                b_valid;
  logic [CW-1:0]       b_col;
  gtmf_pkg::pix_info_t b_info;
  logic [8:0]          win;
  logic [8:0]          win_next;
  logic [2:0]          cnt;
  gtmf_pkg::res_t      slot [4];
  gtmf_pkg::res_t      pk [4];
  logic [2:0]          n;
  logic                above;
  logic                two_above;
  logic                c_ge1;
  logic                c_ge2;
  logic                r_ge1;
  logic                r_ge2;
  logic [1:0]          top;
  logic [1:0]          left;
  logic [1:0]          top_cur;
  logic [1:0]          left_cur;
  logic                c_free;
  logic                b_adv;
  logic [gtmf_pkg::ROW_W-1:0]     row_m1;
  logic [gtmf_pkg::COL_OUT_W-1:0] col_out;
  logic [gtmf_pkg::COL_OUT_W-1:0] col_m1;

  assign above     = line_rd[0];
  assign two_above = line_rd[1];

  assign win_next = {b_info.x, win[8:7], above, win[5:4], two_above, win[2:1]};

  assign c_ge1    = b_col != '0;
  assign c_ge2    = 32'(b_col) >= 32'd2;
  assign r_ge1    = b_info.row != '0;
  assign r_ge2    = b_info.row >= 12'd2;
  assign top      = r_ge2 ? 2'd0 : 2'd1;
  assign left     = c_ge2 ? 2'd0 : 2'd1;
  assign top_cur  = r_ge1 ? 2'd1 : 2'd2;
  assign left_cur = c_ge1 ? 2'd1 : 2'd2;
  assign row_m1   = b_info.row - 12'd1;
  assign col_out  = gtmf_pkg::COL_OUT_W'(b_col);
  assign col_m1   = col_out - 10'd1;

  always_comb begin
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      pk[i] = '0;
    end
    if (r_ge1 && c_ge1) begin
      pk[n[1:0]].white   = gtmf_pkg::majority(win_next, top, left);
      pk[n[1:0]].out_row = row_m1;
      pk[n[1:0]].out_col = col_m1;
      n = n + 3'd1;
    end
    if (b_info.last_row && c_ge1) begin
      pk[n[1:0]].white   = gtmf_pkg::majority(win_next, top_cur, left);
      pk[n[1:0]].out_row = b_info.row;
      pk[n[1:0]].out_col = col_m1;
      n = n + 3'd1;
    end
    if (b_info.last_col && r_ge1) begin
      pk[n[1:0]].white   = gtmf_pkg::majority(win_next, top, left_cur);
      pk[n[1:0]].out_row = row_m1;
      pk[n[1:0]].out_col = col_out;
      n = n + 3'd1;
    end
    if (b_info.last_col && b_info.last_row) begin
      pk[n[1:0]].white   = gtmf_pkg::majority(win_next, top_cur, left_cur);
      pk[n[1:0]].out_row = b_info.row;
      pk[n[1:0]].out_col = col_out;
      n = n + 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i + 1) == n) begin
        pk[i].last_of_run = 1'b1;
        pk[i].frame_done  = b_info.last_col && b_info.last_row;
      end
    end
  end

  assign c_free  = (cnt == 3'd0) || (cnt == 3'd1 && res.ready);
  assign b_adv   = b_valid && (n == 3'd0 || c_free);
  assign b_ready = !b_valid || b_adv;

  assign line_wr_en   = b_adv;
  assign line_wr_addr = b_col;
  assign line_wr_data = {above, b_info.x};

  assign res.valid       = cnt != 3'd0;
  assign res.white       = slot[0].white;
  assign res.out_row     = slot[0].out_row;
  assign res.out_col     = slot[0].out_col;
  assign res.last_of_run = slot[0].last_of_run;
  assign res.frame_done  = slot[0].frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      win     <= '0;
      cnt     <= 3'd0;
    end else begin
      if (load) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        win <= win_next;
      end
      if (b_adv && n != 3'd0) begin
        cnt <= n;
      end else if (res.valid && res.ready) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_col  <= col_in;
      b_info <= info_in;
    end
    if (b_adv && n != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        slot[i] <= pk[i];
      end
    end else if (res.valid && res.ready) begin
      for (int i = 0; i < 3; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

FILE: src/gray_threshold_majority_filter.sv
// Gray threshold with 3x3 majority filter over a raster pixel stream.
// Path: an accepted item is registered in the window stage, its results in the queue.
// Throughput if res ready: one item per cycle, set by the single result port: a row's last
// item has two results below row 0, a last-row item past col 0 two, the frame's last four.
// Reset clears counters, window, queue and registers to defaults; the line stores
// are not cleared and need no clearing pass. Depends on gtmf_pkg and all modules.
module gray_threshold_majority_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gtmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtmf_pkg::CFG_DATA_W-1:0] cfg_data,
  gtmf_pix_if.sink                        pix,
  gtmf_res_if.source                      res
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [7:0]          threshold;
  logic [10:0]         frame_width;
  logic [11:0]         frame_height;
  logic                accept;
  logic                b_ready;
  logic [CW-1:0]       col;
  gtmf_pkg::pix_info_t info;
  logic [1:0]          line_rd;
  logic                line_wr_en;
  logic [CW-1:0]       line_wr_addr;
  logic [1:0]          line_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= gtmf_pkg::THRESHOLD_RESET;
      frame_width  <= gtmf_pkg::FRAME_WIDTH_RESET;
      frame_height <= gtmf_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gtmf_pkg::CFG_THRESHOLD: begin
          threshold <= cfg_data[7:0];
        end
        gtmf_pkg::CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[10:0];
        end
        gtmf_pkg::CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[11:0];
        end
        default: begin
        end
      endcase
    end
  end

  gtmf_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .threshold(threshold),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .b_ready(b_ready),
    .accept(accept),
    .col(col),
    .info(info)
  );

  // Bit 0 holds the row above, bit 1 the row two above.
  gtmf_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk(clk),
    .wr_en(line_wr_en),
    .wr_addr(line_wr_addr),
    .wr_data(line_wr_data),
    .rd_en(accept),
    .rd_addr(col),
    .rd_data(line_rd)
  );

  gtmf_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .load(accept),
    .col_in(col),
    .info_in(info),
    .line_rd(line_rd),
    .b_ready(b_ready),
    .line_wr_en(line_wr_en),
    .line_wr_addr(line_wr_addr),
    .line_wr_data(line_wr_data),
    .res(res)
  );

endmodule
